// ===== hw/rtl/ptk_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-group top-K package
// Shared sizes, row type, memory request type and the reset row contents.
// ----------------------------------------------------------------------------
package ptk_pkg;

    localparam int LIST_LEN    = 5;
    localparam int GROUPS      = 8;
    localparam int TIME_W      = 32;
    localparam int GROUP_IDX_W = 3;
    localparam int GRP_AW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    localparam int BASE_TIME = 60 * 60 * 10;
    localparam int STEP_TIME = 60 * 60;

    typedef logic signed [TIME_W-1:0] time_t;
    typedef logic [LIST_LEN-1:0][TIME_W-1:0] row_t;

    // Write and read request into the row memory.
    typedef struct packed {
        logic              rd_en;
        logic [GRP_AW-1:0] rd_addr;
        logic              wr_en;
        logic [GRP_AW-1:0] wr_addr;
        row_t              wr_row;
    } mem_req_t;

    // Contents of every row after reset: slot j holds the start time plus j steps.
    function automatic row_t reset_row();
        row_t r;
        for (int j = 0; j < LIST_LEN; j++) begin
            r[j] = TIME_W'(BASE_TIME + STEP_TIME * j);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ptk_row_mem.sv =====
// ----------------------------------------------------------------------------
// Row memory
// One row of LIST_LEN times per group, registered read. A per-row
// valid bit makes a row that was never written read as the reset row.
// ----------------------------------------------------------------------------
module ptk_row_mem
    import ptk_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mem_req_t req,
    output row_t     rd_row
);

    row_t               mem_array [GROUPS];
    logic [GROUPS-1:0]  row_vld_reg;
    row_t               rd_data_reg;
    logic               rd_vld_reg;

    // Storage write and registered read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[req.wr_addr] <= req.wr_row;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_array[req.rd_addr];
        end
    end

    // Row valid bits, cleared by reset, and the valid bit of the read row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (req.wr_en) begin
                row_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    // A row never written reads as its reset contents.
    assign rd_row = rd_vld_reg ? rd_data_reg : reset_row();

endmodule

// ===== hw/rtl/ptk_row_update.sv =====
// ----------------------------------------------------------------------------
// Row update
// Parallel compare of the candidate against every slot and the shifted row
// with the candidate placed at the first qualifying slot.
// ----------------------------------------------------------------------------
module ptk_row_update
    import ptk_pkg::*;
(
    input  row_t  old_row,
    input  time_t cand,
    output row_t  new_row,
    output logic  hit
);

    logic [LIST_LEN-1:0] take;
    logic [LIST_LEN-1:0] past;

    // A slot takes the candidate when it is empty (negative) or greater.
    always_comb begin
        for (int i = 0; i < LIST_LEN; i++) begin
            take[i] = time_t'(old_row[i]) < 0 || time_t'(old_row[i]) > cand;
        end
    end

    // Slots after the insertion point take the entry one place up.
    always_comb begin
        past[0] = 1'b0;
        for (int i = 1; i < LIST_LEN; i++) begin
            past[i] = past[i-1] | take[i-1];
        end
    end

    always_comb begin
        new_row[0] = take[0] ? cand : old_row[0];
        for (int i = 1; i < LIST_LEN; i++) begin
            if (past[i]) begin
                new_row[i] = old_row[i-1];
            end else if (take[i]) begin
                new_row[i] = cand;
            end else begin
                new_row[i] = old_row[i];
            end
        end
    end

    assign hit = |take;

endmodule

// ===== hw/rtl/per_group_top_k_time_insert.sv =====
// ----------------------------------------------------------------------------
// Per-group top-K time insertion
// Keeps an ascending list of the best times for each group in a row memory
// and inserts each new time with at most one read and one write of its group's row.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                          | Handshake
//  input   | in        | s_group_index, s_new_time      | s_valid / s_ready
//  result  | out       | m_inserted, m_bad_group        | m_valid / m_ready
//
// Each transaction reads its row on accept; the row is updated and written back
// in the update step, which holds until the output register frees.
// Reset is synchronous and active low; rows read as their start contents until
// first written, so no clearing pass is needed.
// The result waits in an output register; a following input transaction is
// accepted meanwhile and holds in its update step until that register frees.
// ----------------------------------------------------------------------------
module per_group_top_k_time_insert
    import ptk_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [GROUP_IDX_W-1:0] s_group_index,
    input  logic signed [TIME_W-1:0] s_new_time,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_inserted,
    output logic                   m_bad_group
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t   state_reg, state_next;
    time_t    time_reg;
    logic     bad_reg;
    logic [GRP_AW-1:0] grp_reg;
    logic     m_valid_reg, m_valid_next;
    logic     m_inserted_reg, m_bad_group_reg;

    mem_req_t mem_req;
    row_t     old_row;
    row_t     new_row;
    logic     hit;
    logic     s_fire;
    logic     out_free;
    logic     finish;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_UPDATE) && out_free;

    ptk_row_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_row  (old_row)
    );

    ptk_row_update u_upd (
        .old_row (old_row),
        .cand    (time_reg),
        .new_row (new_row),
        .hit     (hit)
    );

    // Memory request: read a valid group on accept, write a changed row on finish.
    always_comb begin
        mem_req.rd_en   = s_fire && (32'(s_group_index) < GROUPS);
        mem_req.rd_addr = s_group_index[GRP_AW-1:0];
        mem_req.wr_en   = finish && !bad_reg && hit;
        mem_req.wr_addr = grp_reg;
        mem_req.wr_row  = new_row;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Captured transaction and result payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            time_reg <= s_new_time;
            grp_reg  <= s_group_index[GRP_AW-1:0];
            bad_reg  <= !(32'(s_group_index) < GROUPS);
        end
        if (finish) begin
            m_inserted_reg  <= !bad_reg && hit;
            m_bad_group_reg <= bad_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_inserted  = m_inserted_reg;
    assign m_bad_group = m_bad_group_reg;

`ifndef SYNTHESIS
    // A rejected group never reports an insert.
    a_bad_no_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_inserted && m_bad_group))
        else $error("insert reported for an out-of-range group");

    // The memory is written only while a transaction finishes.
    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == ST_UPDATE) && out_free)
        else $error("row write outside the update step");

    // Every accepted transaction moves to the update step.
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_UPDATE)
        else $error("accepted transaction not processed");

    // A new result appears only after an update step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_UPDATE))
        else $error("result without an update step");
`endif

endmodule
